>>> src/wsfp_pkg.sv
// WebSocket frame parser: shared types and constants.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
`default_nettype none

package wsfp_pkg;

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Header byte counter value on the last byte of each field
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  // Queue between front and back; depth must be a power of two
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One classified beat, ready for the back end
  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
  } wsfp_entry_t;

  typedef struct packed {
    logic        valid;
    wsfp_entry_t entry;
  } wsfp_push_t;

  typedef struct packed {
    logic        valid;
    wsfp_entry_t entry;
  } wsfp_head_t;

endpackage

`default_nettype wire

>>> src/wsfp_in_if.sv
// Input byte channel of the WebSocket frame parser.
// Standalone valid/ready interface; no package dependency.
`default_nettype none

interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> src/wsfp_out_if.sv
// Result channel of the WebSocket frame parser.
// Standalone valid/ready interface; no package dependency.
`default_nettype none

interface wsfp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        fin_flag;
  logic [3:0]  frame_opcode;
  logic        masked_flag;
  logic [63:0] payload_length;
  logic [7:0]  out_byte;
  logic        last_of_frame;

  modport source (output valid, output result_kind, output fin_flag, output frame_opcode,
                  output masked_flag, output payload_length, output out_byte,
                  output last_of_frame, input ready);
  modport sink   (input valid, input result_kind, input fin_flag, input frame_opcode,
                  input masked_flag, input payload_length, input out_byte,
                  input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> src/wsfp_front.sv
// Front end: header parser state machine, classifies each input beat.
// Depends on wsfp_pkg and wsfp_in_if; pushes entries into wsfp_fifo.
`default_nettype none

module wsfp_front (
  input  logic               clk,
  input  logic               rst,
  wsfp_in_if.sink            in_ch,
  input  logic               q_full,
  output wsfp_pkg::wsfp_push_t push
);
  import wsfp_pkg::*;

  typedef enum logic [2:0] {
    PH_BYTE1,
    PH_BYTE2,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask, mask_next;
  logic [63:0] length, length_next;
  logic [2:0]  hcount, hcount_next;
  logic [31:0] key, key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  midx, midx_next;

  logic        accept;
  logic        length_done;
  logic        finish;
  logic [7:0]  b;
  logic [2:0]  need;
  logic [7:0]  key_byte;
  logic        pay_last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign need        = (phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
  assign pay_last    = (remaining == 64'd1);

  always_comb begin
    case (midx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  always_comb begin
    phase_next     = phase;
    fin_next       = fin;
    opcode_next    = opcode;
    mask_next      = mask;
    length_next    = length;
    hcount_next    = hcount;
    key_next       = key;
    remaining_next = remaining;
    midx_next      = midx;
    length_done    = 1'b0;
    finish         = 1'b0;
    push           = '0;

    if (accept) begin
      case (phase)
        PH_BYTE2: begin
          mask_next   = b[7];
          key_next    = '0;
          hcount_next = '0;
          if (b[6:0] == LEN7_EXT16) begin
            length_next = '0;
            phase_next  = PH_EXT16;
          end else if (b[6:0] == LEN7_EXT64) begin
            length_next = '0;
            phase_next  = PH_EXT64;
          end else begin
            length_next = {57'd0, b[6:0]};
            length_done = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          length_next = {length[55:0], b};
          if (hcount >= need) length_done = 1'b1;
          else hcount_next = hcount + 3'd1;
        end
        PH_KEY: begin
          key_next = {key[23:0], b};
          if (hcount >= KEY_LAST) finish = 1'b1;
          else hcount_next = hcount + 3'd1;
        end
        PH_PAYLOAD: begin
          midx_next           = midx + 2'd1;
          remaining_next      = remaining - 64'd1;
          if (pay_last) phase_next = PH_BYTE1;
          push.valid          = 1'b1;
          push.entry.kind     = KIND_PAYLOAD;
          push.entry.fin      = fin;
          push.entry.opcode   = opcode;
          push.entry.masked   = mask;
          push.entry.length   = length;
          push.entry.data     = b;
          push.entry.key      = mask ? key_byte : 8'd0;
          push.entry.last     = pay_last;
        end
        default: begin
          // first header byte; unused codes fall back here
          fin_next    = b[7];
          opcode_next = b[3:0];
          phase_next  = PH_BYTE2;
        end
      endcase

      if (length_done) begin
        hcount_next = '0;
        if (mask_next) phase_next = PH_KEY;
        else finish = 1'b1;
      end

      if (finish) begin
        remaining_next    = length_next;
        midx_next         = '0;
        hcount_next       = '0;
        phase_next        = (length_next == 64'd0) ? PH_BYTE1 : PH_PAYLOAD;
        push.valid        = 1'b1;
        push.entry.kind   = KIND_HEADER;
        push.entry.fin    = fin_next;
        push.entry.opcode = opcode_next;
        push.entry.masked = mask_next;
        push.entry.length = length_next;
        push.entry.data   = 8'd0;
        push.entry.key    = 8'd0;
        push.entry.last   = (length_next == 64'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_BYTE1;
      fin       <= 1'b0;
      opcode    <= '0;
      mask      <= 1'b0;
      length    <= '0;
      hcount    <= '0;
      key       <= '0;
      remaining <= '0;
      midx      <= '0;
    end else begin
      phase     <= phase_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
      mask      <= mask_next;
      length    <= length_next;
      hcount    <= hcount_next;
      key       <= key_next;
      remaining <= remaining_next;
      midx      <= midx_next;
    end
  end

  // payload phase always has at least one byte left
  a_remaining_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != 64'd0)
    else $error("payload phase with zero bytes remaining");

  // nothing is queued without an accepted beat
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> accept)
    else $error("entry pushed without accepted beat");

  // a non-empty frame header leads into the payload
  a_header_to_payload: assert property (@(posedge clk) disable iff (rst)
    push.valid && push.entry.kind == KIND_HEADER && !push.entry.last |=> phase == PH_PAYLOAD)
    else $error("header result not followed by payload phase");

endmodule

`default_nettype wire

>>> src/wsfp_fifo.sv
// Short queue between parser front end and output back end.
// Depends on wsfp_pkg (entry types, depth constants).
`default_nettype none

module wsfp_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  wsfp_pkg::wsfp_push_t push,
  output logic                 full,
  input  logic                 pop,
  output wsfp_pkg::wsfp_head_t head
);
  import wsfp_pkg::*;

  wsfp_entry_t             slots [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> src/wsfp_back.sv
// Back end: unmasks payload beats and holds the result register.
// Depends on wsfp_pkg and wsfp_out_if; pops entries from wsfp_fifo.
`default_nettype none

module wsfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wsfp_pkg::wsfp_head_t head,
  output logic                 pop,
  wsfp_out_if.source           out_ch
);
  import wsfp_pkg::*;

  logic        valid;
  logic        kind;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] length;
  logic [7:0]  data;
  logic        last;

  // load when the result register is free or being emptied this cycle
  assign pop = head.valid && (!valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind   <= head.entry.kind;
      fin    <= head.entry.fin;
      opcode <= head.entry.opcode;
      masked <= head.entry.masked;
      length <= head.entry.length;
      data   <= head.entry.data ^ head.entry.key;
      last   <= head.entry.last;
    end
  end

  assign out_ch.valid          = valid;
  assign out_ch.result_kind    = kind;
  assign out_ch.fin_flag       = fin;
  assign out_ch.frame_opcode   = opcode;
  assign out_ch.masked_flag    = masked;
  assign out_ch.payload_length = length;
  assign out_ch.out_byte       = data;
  assign out_ch.last_of_frame  = last;

endmodule

`default_nettype wire

>>> src/websocket_frame_parser_top.sv
// WebSocket frame parser top level; depends on wsfp_pkg, wsfp_in_if, wsfp_out_if, front/fifo/back.
// Path: an accepted byte's result is written into the queue, then moved into the output register.
// Throughput: one byte per cycle sustained; the input stalls only while the 4-entry
//   queue is full, which happens only after the output side has held off.
// Reset: synchronous, active high; parser waits for the first header byte, queue empty.
`default_nettype none

module websocket_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  wsfp_in_if.sink     in_ch,
  wsfp_out_if.source  out_ch
);
  import wsfp_pkg::*;

  // Front end walks the header (first byte, length byte, optional 16- or
  // 64-bit extended length, optional 4-byte key). Only the beat that closes
  // the header and each payload beat push an entry; other header beats are
  // consumed silently.
  wsfp_push_t push;
  logic       q_full;

  // Queue decouples parsing from the output handshake; the input stays
  // ready as long as the queue has room, even while a result waits.
  wsfp_head_t head;
  logic       pop;

  wsfp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  wsfp_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  // Back end applies the key byte picked by the front end (zero when the
  // frame is unmasked or for header beats) and registers the result.
  // The result register starts empty after reset.
  wsfp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> verif/websocket_frame_parser_top_test.sv
// Self-checking testbench for websocket_frame_parser_top: streams raw frame bytes in and
// checks every header and payload beat against an in-bench parser model or a typed-in table result.
// Depends on wsfp_pkg, wsfp_in_if, wsfp_out_if and the parser RTL.
`default_nettype none

module websocket_frame_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfp_pkg::*;

  localparam int IDLE_PCT     = 27;      // chance in 100 that a side idles in a cycle
  localparam int RANDOM_BYTES = 430;     // random stream bytes after the directed table
  localparam int HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 10;      // generous margin at the end
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 50;

  // One result beat, field for field as on the output channel
  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  data;
    logic        last;
  } frame_result_t;

  // Directed table row: the byte, and a typed-in result where one is obvious
  typedef struct packed {
    logic [7:0]    b;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  typedef enum logic [2:0] {
    ST_HDR0  = 3'd0,
    ST_HDR1  = 3'd1,
    ST_EXT16 = 3'd2,
    ST_EXT64 = 3'd3,
    ST_KEY   = 3'd4,
    ST_DATA  = 3'd5
  } parse_state_e;

  logic clk;
  logic rst;

  wsfp_in_if  in_ch ();
  wsfp_out_if out_ch ();

  websocket_frame_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser model state, as after reset
  // ---------------------------------------------------------------------------
  parse_state_e st       = ST_HDR0;
  logic         fin_q    = 1'b0;
  logic [3:0]   op_q     = 4'd0;
  logic         mask_q   = 1'b0;
  logic [63:0]  len_q    = 64'd0;
  logic [2:0]   hcnt     = 3'd0;   // bytes seen of the current header field
  logic [31:0]  key_q    = 32'd0;
  logic [63:0]  left_q   = 64'd0;  // payload bytes still to come
  logic [1:0]   kidx     = 2'd0;   // key byte index for the next payload byte

  frame_result_t results_due [$];  // expected output beats, oldest first

  // Bookkeeping
  int  bytes_in      = 0;
  int  beats_out     = 0;
  int  headers_out   = 0;
  int  frames_closed = 0;
  int  mismatches    = 0;
  int  cycle_count   = 0;
  bit  quiet         = 1'b0;   // both sides run without idling
  int  hold_asks     = 0;      // bumped by the stimulus to request a hold-off
  int  holds_served  = 0;
  int  hold_left     = 0;

  // Advance the model by one stream byte; returns 1 when a result beat comes out.
  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
    logic [2:0] need;
    logic [7:0] v;
    bit         len_done;
    bit         hdr_done;
    bit         emit;
    r        = '0;
    v        = b;
    len_done = 1'b0;
    hdr_done = 1'b0;
    emit     = 1'b0;
    case (st)
      ST_HDR1: begin
        mask_q = b[7];
        key_q  = 32'd0;
        hcnt   = 3'd0;
        len_q  = 64'd0;
        if (b[6:0] == LEN7_EXT16) st = ST_EXT16;
        else if (b[6:0] == LEN7_EXT64) st = ST_EXT64;
        else begin
          len_q    = {57'd0, b[6:0]};
          len_done = 1'b1;
        end
      end
      ST_EXT16, ST_EXT64: begin
        need  = (st == ST_EXT16) ? EXT16_LAST : EXT64_LAST;
        len_q = {len_q[55:0], b};
        if (hcnt >= need) len_done = 1'b1;
        else hcnt = hcnt + 3'd1;
      end
      ST_KEY: begin
        key_q = {key_q[23:0], b};
        if (hcnt >= KEY_LAST) hdr_done = 1'b1;
        else hcnt = hcnt + 3'd1;
      end
      ST_DATA: begin
        if (mask_q) v = b ^ key_q[(3 - int'(kidx)) * 8 +: 8];
        kidx   = kidx + 2'd1;
        left_q = left_q - 64'd1;
        if (left_q == 64'd0) st = ST_HDR0;
        r    = '{KIND_PAYLOAD, fin_q, op_q, mask_q, len_q, v, left_q == 64'd0};
        emit = 1'b1;
      end
      default: begin
        // reserved bits 6..4 are dropped
        fin_q = b[7];
        op_q  = b[3:0];
        st    = ST_HDR1;
      end
    endcase
    if (len_done) begin
      hcnt = 3'd0;
      if (mask_q) st = ST_KEY;
      else hdr_done = 1'b1;
    end
    if (hdr_done) begin
      left_q = len_q;
      kidx   = 2'd0;
      hcnt   = 3'd0;
      st     = (len_q == 64'd0) ? ST_HDR0 : ST_DATA;
      r      = '{KIND_HEADER, fin_q, op_q, mask_q, len_q, 8'd0, len_q == 64'd0};
      emit   = 1'b1;
    end
    return emit;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one byte; on acceptance run the model and queue what it predicts.
  // Typed table rows replace the model's result with the typed-in one.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_result_t want = '0);
    frame_result_t pred;
    bit            emits;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_in++;
    emits = parse_byte(b, pred);
    if (emits) results_due.insert(results_due.size(), typed ? want : pred);
  endtask

  // Sender stops and waits for the output to drain completely.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One frame from the random part. Well-formed frames keep the reserved bits clear;
  // noisy ones take byte one whole and any 7-bit length. Lengths stay short so the
  // parser keeps cycling through headers.
  task automatic send_frame(input bit noisy);
    logic [7:0]  b1;
    logic        masked;
    logic [6:0]  code;
    logic [63:0] len;
    int          form;
    masked = 1'($urandom_range(1));
    form   = $urandom_range(99);
    if (noisy) begin
      b1   = 8'($urandom_range(255));
      len  = 64'($urandom_range(125));
      code = len[6:0];
    end else begin
      b1 = {1'($urandom_range(1)), 3'b000, 4'($urandom_range(15))};
      if (form < 3) begin
        len  = 64'd125;                       // longest 7-bit length
        code = len[6:0];
      end else if (form < 70) begin
        len  = 64'($urandom_range(9));
        code = len[6:0];
      end else if (form < 72) begin
        len  = 64'($urandom_range(300, 256)); // both bytes of the 16-bit form in use
        code = LEN7_EXT16;
      end else if (form < 86) begin
        len  = 64'($urandom_range(24));
        code = LEN7_EXT16;
      end else begin
        len  = 64'($urandom_range(24));
        code = LEN7_EXT64;
      end
    end
    send_byte(b1);
    send_byte({masked, code});
    if (code == LEN7_EXT16) begin
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end else if (code == LEN7_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom_range(255)));
    repeat (int'(len)) send_byte(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, calm stretches, and a long hold-off on request.
  // The hold-off is counted here, independent of the sender.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_asks != holds_served) begin
      holds_served <= hold_asks;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: each beat against the oldest expectation, field by field
  // ---------------------------------------------------------------------------
  frame_result_t seen;
  frame_result_t due;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.result_kind, out_ch.fin_flag, out_ch.frame_opcode, out_ch.masked_flag,
               out_ch.payload_length, out_ch.out_byte, out_ch.last_of_frame};
      beats_out++;
      if (seen.kind == KIND_HEADER) headers_out++;
      if (seen.last) frames_closed++;
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing expected: %h", seen));
      end else begin
        due = results_due.pop_front();
        if (seen.kind !== due.kind)
          flag_mismatch($sformatf("result_kind got %0d want %0d", seen.kind, due.kind));
        if (seen.fin !== due.fin)
          flag_mismatch($sformatf("fin_flag got %0d want %0d", seen.fin, due.fin));
        if (seen.opcode !== due.opcode)
          flag_mismatch($sformatf("frame_opcode got %h want %h", seen.opcode, due.opcode));
        if (seen.masked !== due.masked)
          flag_mismatch($sformatf("masked_flag got %0d want %0d", seen.masked, due.masked));
        if (seen.length !== due.length)
          flag_mismatch($sformatf("payload_length got %h want %h", seen.length, due.length));
        if (seen.data !== due.data)
          flag_mismatch($sformatf("out_byte got %h want %h", seen.data, due.data));
        if (seen.last !== due.last)
          flag_mismatch($sformatf("last_of_frame got %0d want %0d", seen.last, due.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [$];
  int        frame_no;

  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_rows = '{
      // zero length: header beat closes the frame (ping, FIN set)
      '{8'h89, 1'b0, '0},
      '{8'h00, 1'b1, '{KIND_HEADER, 1'b1, 4'h9, 1'b0, 64'd0, 8'h00, 1'b1}},
      // reserved bits set, opcode 0xF, masked, one byte; key byte 0 is 0xFF
      '{8'h7F, 1'b0, '0},
      '{8'h81, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h55, 1'b1, '{KIND_HEADER, 1'b0, 4'hF, 1'b1, 64'd1, 8'h00, 1'b0}},
      '{8'hFF, 1'b1, '{KIND_PAYLOAD, 1'b0, 4'hF, 1'b1, 64'd1, 8'h00, 1'b1}},
      // 16-bit extended length of 2, unmasked
      '{8'h82, 1'b0, '0},
      '{8'h7E, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h02, 1'b1, '{KIND_HEADER, 1'b1, 4'h2, 1'b0, 64'd2, 8'h00, 1'b0}},
      '{8'h12, 1'b0, '0},
      '{8'h34, 1'b0, '0},
      // 64-bit extended length of 1, unmasked, opcode 0
      '{8'h00, 1'b0, '0},
      '{8'h7F, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h01, 1'b1, '{KIND_HEADER, 1'b0, 4'h0, 1'b0, 64'd1, 8'h00, 1'b0}},
      '{8'h5A, 1'b0, '0}
    };
    foreach (directed_rows[k])
      send_byte(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].want);
    drain_outputs();

    // Random part: mostly well-formed frames with random content, some noisy headers
    frame_no = 0;
    while (bytes_in < directed_rows.size() + RANDOM_BYTES) begin
      quiet = (frame_no >= 3 && frame_no < 8);
      if (frame_no == 1) hold_asks++;      // receiver stalls while we keep offering
      if (frame_no == 9) drain_outputs();  // sender pauses until all beats are out
      send_frame($urandom_range(99) < 20);
      frame_no++;
    end
    quiet = 1'b0;

    // Last: all-ones 64-bit length (top bit set), masked; the frame never closes
    send_byte(8'h8A);
    send_byte(8'hFF);
    repeat (8) send_byte(8'hFF);
    repeat (4) send_byte(8'($urandom_range(255)));
    repeat (24) send_byte(8'($urandom_range(255)));

    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes in %0d random frames plus directed cases; checked %0d beats",
             bytes_in, frame_no, beats_out);
    $display("(%0d headers, %0d closed frames), with backpressure, hold-off and drain pauses.",
             headers_out, frames_closed);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> websocket_frame_parser_top.f
src/wsfp_pkg.sv
src/wsfp_in_if.sv
src/wsfp_out_if.sv
src/wsfp_front.sv
src/wsfp_fifo.sv
src/wsfp_back.sv
src/websocket_frame_parser_top.sv
verif/websocket_frame_parser_top_test.sv
